// File: hdl/pfe_pkg.sv
package pfe_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_TDATA_W = 40;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_DIVZERO   = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_EMPTY     = 3'd4;

    // character classes
    localparam logic [2:0] CLS_PUSH = 3'd0;
    localparam logic [2:0] CLS_ADD  = 3'd1;
    localparam logic [2:0] CLS_SUB  = 3'd2;
    localparam logic [2:0] CLS_MUL  = 3'd3;
    localparam logic [2:0] CLS_DIV  = 3'd4;
    localparam logic [2:0] CLS_POW  = 3'd5;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
    localparam logic [OP_W-1:0] OP_RD_LEFT     = 5'd1;
    localparam logic [OP_W-1:0] OP_LD_OPS      = 5'd2;
    localparam logic [OP_W-1:0] OP_ADD         = 5'd3;
    localparam logic [OP_W-1:0] OP_SUB         = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL_INIT    = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_STEP    = 5'd6;
    localparam logic [OP_W-1:0] OP_MUL_DONE    = 5'd7;
    localparam logic [OP_W-1:0] OP_DIV_INIT    = 5'd8;
    localparam logic [OP_W-1:0] OP_DIV_STEP    = 5'd9;
    localparam logic [OP_W-1:0] OP_DIV_DONE    = 5'd10;
    localparam logic [OP_W-1:0] OP_POW_INIT    = 5'd11;
    localparam logic [OP_W-1:0] OP_MUL_INIT_RS = 5'd12;
    localparam logic [OP_W-1:0] OP_RES_LD      = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL_INIT_SS = 5'd14;
    localparam logic [OP_W-1:0] OP_SQ_LD       = 5'd15;
    localparam logic [OP_W-1:0] OP_POW_DONE    = 5'd16;
    localparam logic [OP_W-1:0] OP_POW_NEG     = 5'd17;
    localparam logic [OP_W-1:0] OP_PUSH        = 5'd18;
    localparam logic [OP_W-1:0] OP_ERR_UNDER   = 5'd19;
    localparam logic [OP_W-1:0] OP_ERR_DIVZ    = 5'd20;
    localparam logic [OP_W-1:0] OP_EMIT        = 5'd21;

    // control from sequencer to datapath
    typedef struct packed {
        logic            take;
        logic [OP_W-1:0] op;
    } ctrl_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic       in_valid;
        logic [2:0] ocls;
        logic       under;
        logic       div_zero;
        logic       cnt_more;
        logic       exp_neg;
        logic       exp_zero;
        logic       exp_even;
        logic       last;
        logic       out_busy;
    } flags_t;

endpackage

// File: hdl/pfe_ram.sv
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/pfe_useq.sv
module pfe_useq (
    input  logic            aclk,
    input  logic            aresetn,
    input  pfe_pkg::flags_t flags,
    output pfe_pkg::ctrl_t  ctrl
);

    localparam int UPC_W = 5;

    // jump conditions
    localparam logic [3:0] C_NEVER    = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_VALID = 4'd2;
    localparam logic [3:0] C_NOT_OPER = 4'd3;
    localparam logic [3:0] C_UNDER    = 4'd4;
    localparam logic [3:0] C_DISPATCH = 4'd5;
    localparam logic [3:0] C_DIVZERO  = 4'd6;
    localparam logic [3:0] C_CNT_MORE = 4'd7;
    localparam logic [3:0] C_EXP_NEG  = 4'd8;
    localparam logic [3:0] C_EXP_ZERO = 4'd9;
    localparam logic [3:0] C_EXP_EVEN = 4'd10;
    localparam logic [3:0] C_NOT_LAST = 4'd11;
    localparam logic [3:0] C_OUT_BUSY = 4'd12;

    // program addresses
    localparam logic [UPC_W-1:0] A_FETCH  = 5'd0;
    localparam logic [UPC_W-1:0] A_DECODE = 5'd1;
    localparam logic [UPC_W-1:0] A_CHKUND = 5'd2;
    localparam logic [UPC_W-1:0] A_RDLEFT = 5'd3;
    localparam logic [UPC_W-1:0] A_LDOPS  = 5'd4;
    localparam logic [UPC_W-1:0] A_ADD    = 5'd5;
    localparam logic [UPC_W-1:0] A_SUB    = 5'd6;
    localparam logic [UPC_W-1:0] A_MUL    = 5'd7;
    localparam logic [UPC_W-1:0] A_MLOOP  = 5'd8;
    localparam logic [UPC_W-1:0] A_MDONE  = 5'd9;
    localparam logic [UPC_W-1:0] A_DIV    = 5'd10;
    localparam logic [UPC_W-1:0] A_DINIT  = 5'd11;
    localparam logic [UPC_W-1:0] A_DLOOP  = 5'd12;
    localparam logic [UPC_W-1:0] A_DDONE  = 5'd13;
    localparam logic [UPC_W-1:0] A_POW    = 5'd14;
    localparam logic [UPC_W-1:0] A_PINIT  = 5'd15;
    localparam logic [UPC_W-1:0] A_PTEST  = 5'd16;
    localparam logic [UPC_W-1:0] A_PODD   = 5'd17;
    localparam logic [UPC_W-1:0] A_PMRS   = 5'd18;
    localparam logic [UPC_W-1:0] A_PLRS   = 5'd19;
    localparam logic [UPC_W-1:0] A_PRES   = 5'd20;
    localparam logic [UPC_W-1:0] A_PMSS   = 5'd21;
    localparam logic [UPC_W-1:0] A_PLSS   = 5'd22;
    localparam logic [UPC_W-1:0] A_PSQ    = 5'd23;
    localparam logic [UPC_W-1:0] A_PDONE  = 5'd24;
    localparam logic [UPC_W-1:0] A_PNEG   = 5'd25;
    localparam logic [UPC_W-1:0] A_PUSH   = 5'd26;
    localparam logic [UPC_W-1:0] A_UNDER  = 5'd27;
    localparam logic [UPC_W-1:0] A_DZ     = 5'd28;
    localparam logic [UPC_W-1:0] A_END    = 5'd29;
    localparam logic [UPC_W-1:0] A_EWAIT  = 5'd30;
    localparam logic [UPC_W-1:0] A_EMIT   = 5'd31;

    typedef struct packed {
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
        pfe_pkg::ctrl_t   ctrl;
    } uword_t;

    function automatic uword_t uw(input logic [3:0] c, input logic [UPC_W-1:0] t,
                                  input logic take, input logic [pfe_pkg::OP_W-1:0] op);
        uword_t w;
        w.cond      = c;
        w.target    = t;
        w.ctrl.take = take;
        w.ctrl.op   = op;
        return w;
    endfunction

    // microprogram
    function automatic uword_t rom_word(input logic [UPC_W-1:0] a);
        uword_t w;
        case (a)
            A_FETCH:  w = uw(C_NO_VALID, A_FETCH, 1'b1, pfe_pkg::OP_NOP);
            A_DECODE: w = uw(C_NOT_OPER, A_PUSH,  1'b0, pfe_pkg::OP_NOP);
            A_CHKUND: w = uw(C_UNDER,    A_UNDER, 1'b0, pfe_pkg::OP_NOP);
            A_RDLEFT: w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_RD_LEFT);
            A_LDOPS:  w = uw(C_DISPATCH, A_END,   1'b0, pfe_pkg::OP_LD_OPS);
            A_ADD:    w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_ADD);
            A_SUB:    w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_SUB);
            A_MUL:    w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_MUL_INIT);
            A_MLOOP:  w = uw(C_CNT_MORE, A_MLOOP, 1'b0, pfe_pkg::OP_MUL_STEP);
            A_MDONE:  w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_MUL_DONE);
            A_DIV:    w = uw(C_DIVZERO,  A_DZ,    1'b0, pfe_pkg::OP_NOP);
            A_DINIT:  w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_DIV_INIT);
            A_DLOOP:  w = uw(C_CNT_MORE, A_DLOOP, 1'b0, pfe_pkg::OP_DIV_STEP);
            A_DDONE:  w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_DIV_DONE);
            A_POW:    w = uw(C_EXP_NEG,  A_PNEG,  1'b0, pfe_pkg::OP_NOP);
            A_PINIT:  w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_POW_INIT);
            A_PTEST:  w = uw(C_EXP_ZERO, A_PDONE, 1'b0, pfe_pkg::OP_NOP);
            A_PODD:   w = uw(C_EXP_EVEN, A_PMSS,  1'b0, pfe_pkg::OP_NOP);
            A_PMRS:   w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_MUL_INIT_RS);
            A_PLRS:   w = uw(C_CNT_MORE, A_PLRS,  1'b0, pfe_pkg::OP_MUL_STEP);
            A_PRES:   w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_RES_LD);
            A_PMSS:   w = uw(C_NEVER,    A_FETCH, 1'b0, pfe_pkg::OP_MUL_INIT_SS);
            A_PLSS:   w = uw(C_CNT_MORE, A_PLSS,  1'b0, pfe_pkg::OP_MUL_STEP);
            A_PSQ:    w = uw(C_ALWAYS,   A_PTEST, 1'b0, pfe_pkg::OP_SQ_LD);
            A_PDONE:  w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_POW_DONE);
            A_PNEG:   w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_POW_NEG);
            A_PUSH:   w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_PUSH);
            A_UNDER:  w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_ERR_UNDER);
            A_DZ:     w = uw(C_ALWAYS,   A_END,   1'b0, pfe_pkg::OP_ERR_DIVZ);
            A_END:    w = uw(C_NOT_LAST, A_FETCH, 1'b0, pfe_pkg::OP_NOP);
            A_EWAIT:  w = uw(C_OUT_BUSY, A_EWAIT, 1'b0, pfe_pkg::OP_NOP);
            A_EMIT:   w = uw(C_ALWAYS,   A_FETCH, 1'b0, pfe_pkg::OP_EMIT);
            default:  w = uw(C_ALWAYS,   A_FETCH, 1'b0, pfe_pkg::OP_NOP);
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           word;
    logic             jump;
    logic [UPC_W-1:0] jtarget;

    assign word = rom_word(upc_reg);
    assign ctrl = word.ctrl;

    always_comb begin
        jtarget = word.target;
        case (word.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_VALID: jump = !flags.in_valid;
            C_NOT_OPER: jump = (flags.ocls == pfe_pkg::CLS_PUSH);
            C_UNDER:    jump = flags.under;
            C_DISPATCH: begin
                jump = 1'b1;
                case (flags.ocls)
                    pfe_pkg::CLS_ADD: jtarget = A_ADD;
                    pfe_pkg::CLS_SUB: jtarget = A_SUB;
                    pfe_pkg::CLS_MUL: jtarget = A_MUL;
                    pfe_pkg::CLS_DIV: jtarget = A_DIV;
                    pfe_pkg::CLS_POW: jtarget = A_POW;
                    default:          jtarget = A_END;
                endcase
            end
            C_DIVZERO:  jump = flags.div_zero;
            C_CNT_MORE: jump = flags.cnt_more;
            C_EXP_NEG:  jump = flags.exp_neg;
            C_EXP_ZERO: jump = flags.exp_zero;
            C_EXP_EVEN: jump = flags.exp_even;
            C_NOT_LAST: jump = !flags.last;
            C_OUT_BUSY: jump = flags.out_busy;
            default:    jump = 1'b0;
        endcase
        upc_next = jump ? jtarget : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // words are taken only at the fetch step
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.take |-> upc_reg == A_FETCH)
        else $error("input taken outside fetch step");

    // a result is only loaded right after the wait step
    assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg == A_EMIT |-> $past(upc_reg) == A_EWAIT && !$past(flags.out_busy))
        else $error("emit entered without a free output register");

    // an operator reaches the dispatch only with two values on the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg == A_RDLEFT |-> !flags.under)
        else $error("operand read with fewer than two values");

endmodule

// File: hdl/pfe_datapath.sv
module pfe_datapath #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pfe_pkg::ctrl_t                       ctrl,
    output pfe_pkg::flags_t                      flags,
    input  logic                                 s_tvalid,
    input  logic [pfe_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pfe_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0]       ram_waddr,
    output logic [VALUE_WIDTH-1:0]               ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(STACK_DEPTH)-1:0]       ram_raddr,
    input  logic [VALUE_WIDTH-1:0]               ram_rdata
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int NW = $clog2(VALUE_WIDTH + 1);
    localparam int VW = pfe_pkg::OUT_VALUE_W;

    function automatic logic [2:0] sym_class(input logic [7:0] sym);
        logic [2:0] c;
        case (sym)
            pfe_pkg::CH_PLUS:  c = pfe_pkg::CLS_ADD;
            pfe_pkg::CH_MINUS: c = pfe_pkg::CLS_SUB;
            pfe_pkg::CH_STAR:  c = pfe_pkg::CLS_MUL;
            pfe_pkg::CH_SLASH: c = pfe_pkg::CLS_DIV;
            pfe_pkg::CH_CARET: c = pfe_pkg::CLS_POW;
            default:           c = pfe_pkg::CLS_PUSH;
        endcase
        return c;
    endfunction

    // top of stack lives in tos_reg, the entries below it in the ram
    logic [W-1:0]    tos_reg, tos_next;
    logic [W-1:0]    opa_reg, opa_next;
    logic [W-1:0]    opb_reg, opb_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    mcand_reg, mcand_next;
    logic [W-1:0]    mplier_reg, mplier_next;
    logic [W-1:0]    res_reg, res_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            qneg_reg, qneg_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [2:0]      err_reg, err_next;
    logic [7:0]      sym_reg, sym_next;
    logic            last_reg, last_next;
    logic            m_valid_reg, m_valid_next;
    logic [VW-1:0]   m_value_reg, m_value_next;
    logic [2:0]      m_err_reg, m_err_next;

    logic [CW-1:0]   count_m1;
    logic [CW-1:0]   count_m2;
    logic [W:0]      rem_sh;
    logic [W:0]      rem_diff;
    logic            count_full;

    assign count_m1   = count_reg - CW'(1);
    assign count_m2   = count_reg - CW'(2);
    assign count_full = (count_reg == CW'(STACK_DEPTH));
    assign rem_sh     = {acc_reg, opa_reg[W-1]};
    assign rem_diff   = rem_sh - {1'b0, opb_reg};

    assign ram_raddr = count_m2[AW-1:0];
    assign ram_re    = (ctrl.op == pfe_pkg::OP_RD_LEFT);
    assign ram_waddr = count_m1[AW-1:0];
    assign ram_wdata = tos_reg;

    always_comb begin
        tos_next     = tos_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        qneg_next    = qneg_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        m_value_next = m_value_reg;
        m_err_next   = m_err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we       = 1'b0;

        if (s_tvalid && ctrl.take) begin
            sym_next  = s_tdata;
            last_next = s_tlast;
        end

        case (ctrl.op)
            pfe_pkg::OP_LD_OPS: begin
                opa_next = ram_rdata;
                opb_next = tos_reg;
            end
            pfe_pkg::OP_ADD: begin
                tos_next   = opa_reg + opb_reg;
                count_next = count_m1;
            end
            pfe_pkg::OP_SUB: begin
                tos_next   = opa_reg - opb_reg;
                count_next = count_m1;
            end
            pfe_pkg::OP_MUL_INIT: begin
                mcand_next  = opa_reg;
                mplier_next = opb_reg;
                acc_next    = '0;
                cnt_next    = NW'(W);
            end
            pfe_pkg::OP_MUL_STEP: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - NW'(1);
            end
            pfe_pkg::OP_MUL_DONE: begin
                tos_next   = acc_reg;
                count_next = count_m1;
            end
            pfe_pkg::OP_DIV_INIT: begin
                qneg_next = opa_reg[W-1] ^ opb_reg[W-1];
                opa_next  = opa_reg[W-1] ? -opa_reg : opa_reg;
                opb_next  = opb_reg[W-1] ? -opb_reg : opb_reg;
                acc_next  = '0;
                cnt_next  = NW'(W);
            end
            pfe_pkg::OP_DIV_STEP: begin
                // restoring step, quotient bits shift into opa
                if (!rem_diff[W]) begin
                    acc_next = rem_diff[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b1};
                end else begin
                    acc_next = rem_sh[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - NW'(1);
            end
            pfe_pkg::OP_DIV_DONE: begin
                tos_next   = qneg_reg ? -opa_reg : opa_reg;
                count_next = count_m1;
            end
            pfe_pkg::OP_POW_INIT: begin
                res_next = W'(1);
            end
            pfe_pkg::OP_MUL_INIT_RS: begin
                mcand_next  = res_reg;
                mplier_next = opa_reg;
                acc_next    = '0;
                cnt_next    = NW'(W);
            end
            pfe_pkg::OP_RES_LD: begin
                res_next = acc_reg;
            end
            pfe_pkg::OP_MUL_INIT_SS: begin
                mcand_next  = opa_reg;
                mplier_next = opa_reg;
                acc_next    = '0;
                cnt_next    = NW'(W);
            end
            pfe_pkg::OP_SQ_LD: begin
                opa_next = acc_reg;
                opb_next = opb_reg >> 1;
            end
            pfe_pkg::OP_POW_DONE: begin
                tos_next   = res_reg;
                count_next = count_m1;
            end
            pfe_pkg::OP_POW_NEG: begin
                // negative exponent: only plus and minus one survive
                if (opa_reg == W'(1)) begin
                    tos_next = W'(1);
                end else if (opa_reg == '1) begin
                    tos_next = opb_reg[0] ? '1 : W'(1);
                end else begin
                    tos_next = '0;
                end
                count_next = count_m1;
            end
            pfe_pkg::OP_PUSH: begin
                if (count_full) begin
                    if (err_reg == pfe_pkg::ERR_OK) begin
                        err_next = pfe_pkg::ERR_OVERFLOW;
                    end
                end else begin
                    ram_we     = (count_reg != '0);
                    tos_next   = W'(sym_reg) - W'(pfe_pkg::CH_ZERO);
                    count_next = count_reg + CW'(1);
                end
            end
            pfe_pkg::OP_ERR_UNDER: begin
                if (err_reg == pfe_pkg::ERR_OK) begin
                    err_next = pfe_pkg::ERR_UNDERFLOW;
                end
            end
            pfe_pkg::OP_ERR_DIVZ: begin
                if (err_reg == pfe_pkg::ERR_OK) begin
                    err_next = pfe_pkg::ERR_DIVZERO;
                end
            end
            pfe_pkg::OP_EMIT: begin
                m_valid_next = 1'b1;
                if (count_reg != '0) begin
                    m_value_next = VW'(signed'(tos_reg));
                    m_err_next   = err_reg;
                end else begin
                    m_value_next = '0;
                    m_err_next   = (err_reg != pfe_pkg::ERR_OK) ? err_reg : pfe_pkg::ERR_EMPTY;
                end
                count_next = '0;
                err_next   = pfe_pkg::ERR_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= pfe_pkg::ERR_OK;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg     <= tos_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        res_reg     <= res_next;
        cnt_reg     <= cnt_next;
        qneg_reg    <= qneg_next;
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        m_value_reg <= m_value_next;
        m_err_reg   <= m_err_next;
    end

    assign flags.in_valid = s_tvalid;
    assign flags.ocls     = sym_class(sym_reg);
    assign flags.under    = (count_reg < CW'(2));
    assign flags.div_zero = (opb_reg == '0);
    assign flags.cnt_more = (cnt_reg != NW'(1));
    assign flags.exp_neg  = opb_reg[W-1];
    assign flags.exp_zero = (opb_reg == '0);
    assign flags.exp_even = !opb_reg[0];
    assign flags.last     = last_reg;
    assign flags.out_busy = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pfe_pkg::OUT_TDATA_W - VW - 3){1'b0}}, m_err_reg, m_value_reg};

    // stack depth stays bounded
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // end of expression clears the stack and the error
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == pfe_pkg::OP_EMIT |=> count_reg == '0 && err_reg == pfe_pkg::ERR_OK)
        else $error("stack not cleared after result");

    // first error of an expression is kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != pfe_pkg::ERR_OK && ctrl.op != pfe_pkg::OP_EMIT |=> err_reg == $past(err_reg))
        else $error("sticky error changed");

    // an emitted result always carries a known error code
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == pfe_pkg::OP_EMIT |=> m_valid_reg && m_err_reg <= pfe_pkg::ERR_EMPTY)
        else $error("bad result word");

endmodule

// File: hdl/postfix_expression_evaluator.sv
// Postfix (reverse Polish) evaluator: each input word carries one expression character in
// s_tdata and s_tlast on its final character. The operators + - * / ^ pop the right and
// then the left operand and push "left op right"; any other character pushes its code minus
// 0x30. Arithmetic is VALUE_WIDTH-bit two's complement: + - * and ^ wrap, / truncates toward
// zero, a negative exponent gives 0 except for bases of plus and minus one. Underflow (1),
// divide by zero (2) and stack overflow (3) are sticky for the expression; the operator or
// push in error is dropped. After the last character one result word leaves on m_: the top
// value (0 if empty) and the error code, 4 meaning the stack ended empty; the stack then
// clears. Control is a 32-step microprogram driving one shift-add multiplier and divider
// datapath, so the time per character depends on the operator and, for ^, on the exponent
// bits up to its highest set bit. A new character is taken only at the fetch step, once the
// previous one is done; a final character also waits while the previous result word still
// sits in the output register. No reset sweep is needed.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfe_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] symbol
    input  logic                            s_tlast,   // last character of the expression
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfe_pkg::OUT_TDATA_W-1:0] m_tdata    // [31:0] value, [34:32] error, rest 0
);

    localparam int AW = $clog2(STACK_DEPTH);

    pfe_pkg::ctrl_t  ctrl;
    pfe_pkg::flags_t flags;

    // ram holds every stack entry below the top
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // input handshake is owned by the microprogram fetch step
    assign s_tready = ctrl.take;

    pfe_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    pfe_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfe_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .flags     (flags),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule
